@@ rtl/rqss_pkg.sv @@
package rqss_pkg;

	// Default depth of the ranking chain.
	localparam int unsigned MAX_ENTRIES_DEF = 64;

	// Reset value of the error threshold, Q0.16 (about 0.3).
	localparam logic [15:0] ERR_THR_RESET = 16'd19660;

	// Reciprocal of five in Q0.16, exact for the quotient of values up to 1024.
	localparam logic [13:0] RECIP5 = 14'd13108;

	// Power mode codes.
	localparam logic [2:0] MODE_STABLE      = 3'd0;
	localparam logic [2:0] MODE_CONSTRAINED = 3'd1;
	localparam logic [2:0] MODE_BATTERY     = 3'd2;

	// One ranked entry as held in a cell.
	typedef struct packed {
		logic [31:0]        id;
		logic signed [31:0] score;
		logic [15:0]        err;
	} entry_t;

	// Control broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic drain;
	} cell_ctl_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

endpackage

@@ rtl/rqss_cell.sv @@
module rqss_cell #(
	parameter int unsigned IDX = 0,
	parameter int unsigned CW  = 7
) (
	input  logic               clk,
	input  rqss_pkg::cell_ctl_t ctl,
	input  logic [CW-1:0]      count,
	input  rqss_pkg::entry_t   new_ent,
	input  rqss_pkg::entry_t   prev_ent,
	input  logic               prev_moves,
	input  rqss_pkg::entry_t   next_ent,
	output rqss_pkg::entry_t   ent_q,
	output logic               moves
);
	import rqss_pkg::*;

	logic occ;

	// The cell is occupied when its position lies below the fill count.
	assign occ = CW'(IDX) < count;

	// The new entry goes ahead of this cell when the cell is empty or scores lower.
	// Equal scores stay ahead, so arrival order is kept on ties.
	assign moves = !occ || (ent_q.score < new_ent.score);

	// Insertion shifts towards the tail; draining shifts towards the head.
	always_ff @(posedge clk) begin
		if (ctl.drain) begin
			ent_q <= next_ent;
		end else if (ctl.ins && moves) begin
			if (prev_moves) begin
				ent_q <= prev_ent;
			end else begin
				ent_q <= new_ent;
			end
		end
	end

endmodule

@@ rtl/rqss_quota.sv @@
module rqss_quota #(
	parameter int unsigned CW = 7
) (
	input  logic [CW-1:0] n,
	input  logic [2:0]    mode,
	output logic [CW-1:0] quota
);
	import rqss_pkg::*;

	logic [CW+1:0]  n4;
	logic [CW+15:0] prod;
	logic [CW-1:0]  q45;

	// Four fifths of n: 4n times the reciprocal of five, then drop the fraction.
	assign n4   = {n, 2'b00};
	assign prod = (CW+16)'(n4) * (CW+16)'(RECIP5);
	assign q45  = prod[CW+15:16];

	// Quota per power mode; critical and unknown modes keep a single entry.
	always_comb begin
		unique case (mode)
			MODE_STABLE:      quota = n;
			MODE_CONSTRAINED: quota = q45;
			MODE_BATTERY:     quota = n >> 1;
			default:          quota = CW'(1);
		endcase
	end

endmodule

@@ rtl/ranked_quota_survival_select_unit.sv @@
// Ranked quota survival selection.
// Requests arrive on the s_axis channel, one entry per cycle while loading:
// tdata carries id, score and error rate, tuser the power mode and tlast
// closes the set. Each entry is inserted into a chain of cells kept in
// descending score order; ties keep arrival order. Entries beyond the chain
// depth are dropped, though a dropped closing request still closes the set.
// On the closing request the quota is taken from the power mode and the set
// size, s_axis_tready drops in the cycle after, and the first result shows on
// m_axis once the output register is free. Results leave at one per cycle
// while the receiver takes them, best rank first, with tlast on the lowest
// rank. A stall holds the output register and freezes the chain. Loading
// restarts as soon as the last result sits in the output register, so the
// next set may load while it waits to be taken. The error threshold is
// written via cfg_we and cfg_wdata; the user must write it only while idle
// (not enforced). Reset empties the chain and output, restores the threshold.
module ranked_quota_survival_select_unit #(
	parameter int unsigned MAX_ENTRIES = rqss_pkg::MAX_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // entry_id, score, entry_err
	input  logic [2:0]  s_axis_tuser,  // power_mode
	input  logic        s_axis_tlast,  // last_entry
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [87:0] m_axis_tdata,  // out_id, out_score, rank, alive, policy_cut,
	                                   // high_error, alive_count, zero padding
	output logic        m_axis_tlast,  // last_result
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata      // error_threshold
);
	import rqss_pkg::*;

	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned RW = (CW > 7) ? CW : 7;

	state_t         state_q, state_d;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  n_next;
	logic [CW-1:0]  n_q;
	logic [CW-1:0]  r_q;
	logic [CW-1:0]  quota;
	logic [CW-1:0]  quota_q;
	logic [15:0]    thr_q;
	logic           s_acc;
	logic           not_full;
	logic           step;
	logic           last_r;
	logic           alive_now;
	cell_ctl_t      ctl;
	entry_t         new_ent;
	entry_t         ent [MAX_ENTRIES];
	logic           moves [MAX_ENTRIES];
	logic [RW-1:0]  rank_w;
	logic [RW-1:0]  acnt_w;

	logic           ovalid_q;
	logic [31:0]    id_q;
	logic [31:0]    score_q;
	logic [6:0]     rank_q;
	logic           alive_q;
	logic           cut_q;
	logic           high_q;
	logic [6:0]     acnt_q;
	logic           olast_q;

	assign new_ent.id    = s_axis_tdata[31:0];
	assign new_ent.score = s_axis_tdata[63:32];
	assign new_ent.err   = s_axis_tdata[79:64];

	assign s_acc    = s_axis_tvalid && s_axis_tready;
	assign not_full = count_q < CW'(MAX_ENTRIES);
	assign n_next   = not_full ? count_q + CW'(1) : count_q;
	assign last_r   = (r_q + CW'(1)) == n_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:  if (s_acc && s_axis_tlast) state_d = ST_DRAIN;
			ST_DRAIN: if (step && last_r) state_d = ST_LOAD;
			default:  state_d = ST_LOAD;
		endcase
	end

	// State outputs: accept while loading, step the drain when the output frees.
	always_comb begin
		s_axis_tready = 1'b0;
		step          = 1'b0;
		unique case (state_q)
			ST_LOAD:  s_axis_tready = 1'b1;
			ST_DRAIN: step = !ovalid_q || m_axis_tready;
			default:  s_axis_tready = 1'b0;
		endcase
	end

	assign ctl.ins   = s_acc && not_full;
	assign ctl.drain = step;

	// Quota of the set being closed.
	rqss_quota #(.CW(CW)) u_quota (
		.n     (n_next),
		.mode  (s_axis_tuser),
		.quota (quota)
	);

	// Chain of sorting cells, position 0 holds the best score.
	for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
		entry_t prev_e;
		logic   prev_m;
		entry_t next_e;
		if (k == 0) begin : g_head
			assign prev_e = new_ent;
			assign prev_m = 1'b0;
		end else begin : g_body
			assign prev_e = ent[k-1];
			assign prev_m = moves[k-1];
		end
		if (k == MAX_ENTRIES - 1) begin : g_tail
			assign next_e = ent[k];
		end else begin : g_mid
			assign next_e = ent[k+1];
		end
		rqss_cell #(.IDX(k), .CW(CW)) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count_q),
			.new_ent    (new_ent),
			.prev_ent   (prev_e),
			.prev_moves (prev_m),
			.next_ent   (next_e),
			.ent_q      (ent[k]),
			.moves      (moves[k])
		);
	end

	// Control registers: state, fill count, set size, drain position, quota.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			n_q     <= '0;
			r_q     <= '0;
			quota_q <= '0;
		end else begin
			state_q <= state_d;
			if (s_acc) begin
				if (s_axis_tlast) begin
					count_q <= '0;
					n_q     <= n_next;
					quota_q <= quota;
					r_q     <= '0;
				end else begin
					count_q <= n_next;
				end
			end else if (step) begin
				r_q <= r_q + CW'(1);
			end
		end
	end

	// Error threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= ERR_THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	assign alive_now = r_q < quota_q;
	assign rank_w    = RW'(r_q) + RW'(1);
	assign acnt_w    = RW'(quota_q);

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (step) begin
			ovalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	// Output register, loaded from the head of the chain.
	always_ff @(posedge clk) begin
		if (step) begin
			id_q    <= ent[0].id;
			score_q <= ent[0].score;
			rank_q  <= rank_w[6:0];
			alive_q <= alive_now;
			cut_q   <= !alive_now;
			high_q  <= !alive_now && (ent[0].err > thr_q);
			acnt_q  <= acnt_w[6:0];
			olast_q <= last_r;
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {7'b0, acnt_q, high_q, cut_q, alive_q, rank_q, score_q, id_q};
	assign m_axis_tlast  = olast_q;

endmodule

@@ rtl/rqss_checker.sv @@
module rqss_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [87:0] m_axis_tdata,
	input logic        m_axis_tlast
);
	import rqss_pkg::*;

	logic [6:0] rank;
	logic       alive;
	logic       cut;
	logic       high;
	logic [6:0] acnt;

	assign rank  = m_axis_tdata[70:64];
	assign alive = m_axis_tdata[71];
	assign cut   = m_axis_tdata[72];
	assign high  = m_axis_tdata[73];
	assign acnt  = m_axis_tdata[80:74];

	// A stalled result holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// Closing a set stops further requests while the set drains.
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("request taken right after closing a set");

	// Alive follows the rank against the alive count, and cut is its opposite.
	a_alive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (alive == (rank <= acnt)) && (cut == !alive))
		else $error("alive flag disagrees with rank and alive count");

	// High error is only ever flagged on a cut entry.
	a_high: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && high |-> cut)
		else $error("high error on a surviving entry");

endmodule

bind ranked_quota_survival_select_unit rqss_checker u_rqss_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
